// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ukf_pkg.sv =====
// Shared types and constants of the unique key queue.
`timescale 1ns / 1ps
package ukf_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int DATA_W = 32;
  localparam int OCC_W = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== hdl/unique_key_fifo.sv =====
// Top level of the unique key queue: cell chain, count and result register.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive operation, key_in and data_in with start high; the
//   beat is taken at a rising edge where start is high and busy is low.
//   operation 0 appends the pair unless its key is already held (status 1)
//   or the queue is full (status 3); operation 1 pops the oldest pair, or
//   reports status 2 when nothing is held.
//   Result channel: one beat per command, shown on status, key_out,
//   data_out, occupancy and is_empty for exactly one cycle with done high.
//   The receiver cannot stall; it must take the beat in that cycle.
// Timing
//   done rises in the cycle after the command is taken.
//   Throughput is one command per cycle while busy is low. The pairs sit in a
//   chain of cells with the oldest in cell 0; a pop shifts every cell one step
//   toward the head, a push loads the cell at the current count, and every
//   cell checks its key against key_in in parallel, so the whole decision is
//   made before the result registers and the next command may follow at once.
// Reset
//   rst clears the queue, the count and done; busy is high while rst is held
//   and until the first rising edge at which rst is low, and low from then on.
`include "assert_macros.svh"
module unique_key_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation,
  input  logic signed [31:0]        key_in,
  input  logic signed [31:0]        data_in,
  output logic                      done,
  output logic [1:0]                status,
  output logic signed [31:0]        key_out,
  output logic signed [31:0]        data_out,
  output logic [4:0]                occupancy,
  output logic                      is_empty
);

  localparam int DEPTH = ukf_pkg::DEPTH;
  localparam int CNT_W = ukf_pkg::CNT_W;

  ukf_pkg::entry_t     ent    [DEPTH];
  ukf_pkg::entry_t     up_ent [DEPTH];
  ukf_pkg::cell_ctrl_t ctrl   [DEPTH];
  logic [DEPTH-1:0]    match_vec;
  logic [DEPTH-1:0]    valid_vec;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                accept;
  logic                hit;
  logic                push;
  logic                pop;
  ukf_pkg::status_t    status_next;
  logic [31:0]         key_out_next;
  logic [31:0]         data_out_next;
  logic                empty_beat;

  assign accept = start && !busy;
  assign hit    = |match_vec;

  // Decide the command: duplicate check wins over the full check.
  always_comb begin
    push          = 1'b0;
    pop           = 1'b0;
    status_next   = ukf_pkg::ST_OK;
    key_out_next  = '0;
    data_out_next = '0;
    count_next    = count;
    if (accept) begin
      case (operation)
        ukf_pkg::OP_ENQ: begin
          if (hit) begin
            status_next = ukf_pkg::ST_DUP;
          end else if (count == CNT_W'(DEPTH)) begin
            status_next = ukf_pkg::ST_FULL;
          end else begin
            push       = 1'b1;
            count_next = count + 1'b1;
          end
        end
        ukf_pkg::OP_DEQ: begin
          if (count == '0) begin
            status_next = ukf_pkg::ST_EMPTY;
          end else begin
            pop           = 1'b1;
            key_out_next  = ent[0].key;
            data_out_next = ent[0].data;
            count_next    = count - 1'b1;
          end
        end
        default: begin
          status_next = ukf_pkg::ST_OK;
        end
      endcase
    end
  end

  // Build the chain: each cell takes its upstream neighbor on a pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      assign up_ent[i] = '0;
    end else begin : g_mid
      assign up_ent[i] = ent[i+1];
    end

    assign ctrl[i]      = '{shift: pop, load: push && (count == CNT_W'(i))};
    assign valid_vec[i] = ent[i].valid;

    ukf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[i]),
      .up       (up_ent[i]),
      .key_new  (key_in),
      .data_new (data_in),
      .ent      (ent[i]),
      .match    (match_vec[i])
    );
  end

  // Hold control state; clear count and done and raise busy on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      busy  <= 1'b1;
    end else begin
      count <= count_next;
      done  <= accept;
      busy  <= 1'b0;
    end
  end

  // Result beat registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      key_out   <= key_out_next;
      data_out  <= data_out_next;
      occupancy <= 5'(count_next);
      is_empty  <= (count_next == '0);
    end
  end

  assign empty_beat = done && (status == ukf_pkg::ST_EMPTY);

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "count beyond depth")
  `ASSERT_ALWAYS(a_valid_count, $countones(valid_vec) == int'(count), "valid cells off count")
  `ASSERT_NEXT(a_done_follows, accept, done, "no result beat after command")
  `ASSERT_NEXT(a_done_spurious, !accept, !done, "result beat without command")
  `ASSERT_SAME(a_empty_zero, empty_beat, is_empty && (key_out == 0), "bad empty result")

endmodule

// ===== hdl/ukf_cell.sv =====
// One queue cell: holds a pair, shifts toward the head, compares its key.
`timescale 1ns / 1ps
module ukf_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  ukf_pkg::cell_ctrl_t      ctrl,
  input  ukf_pkg::entry_t          up,
  input  logic [ukf_pkg::KEY_W-1:0]  key_new,
  input  logic [ukf_pkg::DATA_W-1:0] data_new,
  output ukf_pkg::entry_t          ent,
  output logic                     match
);

  logic                       valid;
  logic [ukf_pkg::KEY_W-1:0]  key;
  logic [ukf_pkg::DATA_W-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= up.valid;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end
  end

  // Payload: take the neighbor's pair on a pop, the new pair on a load.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key  <= up.key;
      data <= up.data;
    end else if (ctrl.load) begin
      key  <= key_new;
      data <= data_new;
    end
  end

  assign ent   = '{valid: valid, key: key, data: data};
  assign match = valid && (key == key_new);

endmodule
